FILE: rtl/pdf_pkg.sv
// Shared constants and power-of-ten table for the padded decimal formatter.
package pdf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 39;
   localparam int TABLE_DEPTH       = 5;
   localparam int POW_W             = 14;
   localparam int MAG_W             = 17;
   localparam int IDX_W             = 3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef logic [POW_W-1:0] pow_type;

   localparam pow_type POWERS [TABLE_DEPTH] = '{
      14'd1, 14'd10, 14'd100, 14'd1000, 14'd10000
   };

endpackage

FILE: rtl/padded_decimal_formatter.sv
// Padded decimal formatter: signed 16-bit value to left-padded ASCII, one character per item.
//
// One request becomes a run of characters: the fill character as padding, a '-' for a
// negative value, then the decimal digits without leading zeros; rsp_last marks the end.
// min_width saturates at MAX_WIDTH. The block takes one request at a time and holds
// req_stall high until the last character is in the output register. A single
// 18-bit subtract/compare unit does all the comparisons and subtractions against the
// power-of-ten table: ST_COUNT sizes the number, then ST_DIVIDE finds each digit by
// repeated subtraction of its power of ten and ST_DIGIT issues it.
module padded_decimal_formatter #(
   parameter int MAX_WIDTH = pdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_value,
   input  logic [5:0]  req_min_width,
   input  logic [7:0]  req_fill_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_COUNT, ST_SIZE, ST_PAD, ST_SIGN, ST_DIVIDE, ST_DIGIT
   } state_type;

   localparam logic [5:0] WIDTH_CAP = 6'(MAX_WIDTH);

   state_type                    state_ff;
   logic                         neg_ff;
   logic [pdf_pkg::MAG_W-1:0]    mag_ff;
   logic [5:0]                   width_ff;
   logic [7:0]                   fill_ff;
   logic [pdf_pkg::IDX_W-1:0]    idx_ff;
   logic [2:0]                   digits_ff;
   logic [5:0]                   pad_ff;
   logic [3:0]                   acc_ff;
   logic                         rsp_valid_ff;
   logic [7:0]                   rsp_char_ff;
   logic                         rsp_last_ff;

   logic                         slot_free;
   logic                         accept;
   logic                         emit_char;
   logic                         rsp_valid_in;
   pdf_pkg::pow_type             pow;
   logic [pdf_pkg::MAG_W:0]      diff;
   logic                         ge;
   logic [2:0]                   body;
   logic [5:0]                   pad_in;
   logic [pdf_pkg::MAG_W-1:0]    mag_in;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign emit_char    = slot_free && ((state_ff == ST_PAD) || (state_ff == ST_SIGN)
                                       || (state_ff == ST_DIGIT));
   assign rsp_valid_in = emit_char || (rsp_valid_ff && rsp_stall);

   // shared subtract / compare unit
   assign pow  = (idx_ff < 3'(pdf_pkg::TABLE_DEPTH)) ? pdf_pkg::POWERS[idx_ff] : '0;
   assign diff = {1'b0, mag_ff} - {4'b0, pow};
   assign ge   = !diff[pdf_pkg::MAG_W];

   assign body   = digits_ff + {2'b0, neg_ff};
   assign pad_in = (width_ff > {3'b0, body}) ? (width_ff - {3'b0, body}) : 6'd0;
   assign mag_in = req_value[15] ? (17'h10000 - {1'b0, req_value}) : {1'b0, req_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  neg_ff    <= req_value[15];
                  mag_ff    <= mag_in;
                  width_ff  <= (req_min_width > WIDTH_CAP) ? WIDTH_CAP : req_min_width;
                  fill_ff   <= req_fill_char;
                  idx_ff    <= 3'd1;
                  digits_ff <= 3'd1;
                  state_ff  <= ST_COUNT;
               end
            end
            ST_COUNT: begin
               if (ge) digits_ff <= digits_ff + 3'd1;
               if (idx_ff == 3'(pdf_pkg::TABLE_DEPTH - 1)) state_ff <= ST_SIZE;
               else idx_ff <= idx_ff + 3'd1;
            end
            ST_SIZE: begin
               pad_ff <= pad_in;
               idx_ff <= digits_ff - 3'd1;
               acc_ff <= 4'd0;
               priority if (pad_in != 6'd0) state_ff <= ST_PAD;
               else if (neg_ff)             state_ff <= ST_SIGN;
               else                         state_ff <= ST_DIVIDE;
            end
            ST_PAD: begin
               if (slot_free) begin
                  rsp_char_ff  <= fill_ff;
                  rsp_last_ff  <= 1'b0;
                  pad_ff       <= pad_ff - 6'd1;
                  if (pad_ff == 6'd1) state_ff <= neg_ff ? ST_SIGN : ST_DIVIDE;
               end
            end
            ST_SIGN: begin
               if (slot_free) begin
                  rsp_char_ff  <= pdf_pkg::CHAR_MINUS;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (ge) begin
                  mag_ff <= diff[pdf_pkg::MAG_W-1:0];
                  acc_ff <= acc_ff + 4'd1;
               end else begin
                  state_ff <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               if (slot_free) begin
                  rsp_char_ff  <= pdf_pkg::CHAR_ZERO + {4'b0, acc_ff};
                  rsp_last_ff  <= (idx_ff == 3'd0);
                  acc_ff       <= 4'd0;
                  if (idx_ff == 3'd0) state_ff <= ST_IDLE;
                  else begin
                     idx_ff   <= idx_ff - 3'd1;
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   a_accept_starts_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_COUNT)
      else $error("accepted item did not start sizing");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> acc_ff <= 4'd9)
      else $error("digit accumulator above nine");

   a_divide_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> idx_ff < 3'(pdf_pkg::TABLE_DEPTH))
      else $error("digit index beyond table");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && slot_free && idx_ff == 3'd0)
      |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("final digit not flagged last");

endmodule

FILE: test/padded_decimal_formatter_tb.sv
// Self-checking testbench for the padded decimal formatter: directed table, then random items.
`timescale 1ns / 1ps

module padded_decimal_formatter_tb;

   localparam int WIDTH_CAP    = pdf_pkg::MAX_WIDTH_DEFAULT;
   localparam int QUIET_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 100;
   localparam int RANDOM_ITEMS = 100;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   typedef struct {
      logic [15:0] value;
      logic [5:0]  min_width;
      logic [7:0]  fill;
      string       golden;
   } stim_row_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [15:0] req_value     = '0;
   logic [5:0]  req_min_width = '0;
   logic [7:0]  req_fill_char = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;

   char_beat_type expected_chars [$];
   string      cur_golden    = "";
   int         idle_pct      = 0;
   int         stall_pct     = 0;
   int         errors        = 0;
   int         items_sent    = 0;
   int         chars_checked = 0;
   int         run_len       = 0;
   int         longest_run   = 0;
   int         quiet_cycles  = 0;

   // empty golden text: expectation comes from the predictor
   stim_row_type directed_rows [21] = '{
      '{16'd0,     6'd0,  " ",   "0"},
      '{16'h7FFF,  6'd0,  " ",   "32767"},
      '{16'h8000,  6'd0,  " ",   "-32768"},
      '{16'hFFFF,  6'd0,  " ",   "-1"},
      '{16'd7,     6'd4,  " ",   "   7"},
      '{16'hFFF9,  6'd4,  "0",   "00-7"},
      '{16'd42,    6'd5,  "*",   "***42"},
      '{16'd12345, 6'd3,  " ",   "12345"},
      '{16'h8000,  6'd6,  "#",   "-32768"},
      '{16'd9,     6'd1,  " ",   "9"},
      '{16'd10,    6'd2,  " ",   "10"},
      '{16'd99,    6'd0,  " ",   "99"},
      '{16'd100,   6'd0,  " ",   "100"},
      '{16'd999,   6'd0,  " ",   "999"},
      '{16'd1000,  6'd0,  " ",   "1000"},
      '{16'd9999,  6'd0,  " ",   "9999"},
      '{16'd10000, 6'd0,  " ",   "10000"},
      '{16'h8000,  6'd63, 8'hFF, ""},
      '{16'd0,     6'd39, 8'h00, ""},
      '{16'hD8F1,  6'd40, ".",   ""},
      '{16'h8001,  6'd38, "0",   ""}
   };

   padded_decimal_formatter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_min_width (req_min_width),
      .req_fill_char (req_fill_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic void queue_expected_run(input logic [15:0] value,
                                              input logic [5:0] min_width,
                                              input logic [7:0] fill, input string golden);
      int unsigned dec_weight [5];
      logic        neg;
      int unsigned mag, width, digits, body, pad, d;
      int          i, pos;
      logic [7:0]  run [$];
      char_beat_type beat;
      dec_weight = '{1, 10, 100, 1000, 10000};
      if (golden.len() != 0) begin
         for (i = 0; i < golden.len(); i++) run.push_back(golden[i]);
      end else begin
         neg    = value[15];
         mag    = neg ? 32'h10000 - {16'h0, value} : {16'h0, value};
         width  = (min_width > WIDTH_CAP) ? WIDTH_CAP : min_width;
         digits = 1;
         for (i = 1; i < 5; i++)
            if (dec_weight[i] <= mag) digits++;
         body = digits + neg;
         pad  = (width > body) ? width - body : 0;
         repeat (pad) run.push_back(fill);
         if (neg) run.push_back(pdf_pkg::CHAR_MINUS);
         for (pos = digits; pos > 0; pos--) begin
            d   = mag / dec_weight[pos-1];
            mag = mag - d * dec_weight[pos-1];
            run.push_back(pdf_pkg::CHAR_ZERO + d[7:0]);
         end
      end
      for (i = 0; i < run.size(); i++) begin
         beat.ch   = run[i];
         beat.last = (i == run.size() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   task automatic send_item(input logic [15:0] value, input logic [5:0] min_width,
                            input logic [7:0] fill, input string golden);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_min_width <= min_width;
      req_fill_char <= fill;
      cur_golden     = golden;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            queue_expected_run(req_value, req_min_width, req_fill_char, cur_golden);
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            run_len++;
            if (expected_chars.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected character %h last %b", rsp_out_char, rsp_last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch || rsp_last !== want.last) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("mismatch at character %0d: expected %h last %b, got %h last %b",
                              chars_checked, want.ch, want.last, rsp_out_char, rsp_last);
               end
            end
            if (rsp_last) begin
               if (run_len > longest_run) longest_run = run_len;
               run_len = 0;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int          phase, n;
      logic [15:0] v;
      logic [5:0]  w;
      logic [7:0]  f;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r])
         send_item(directed_rows[r].value, directed_rows[r].min_width,
                   directed_rows[r].fill, directed_rows[r].golden);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 85; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 85; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
            if (n == 12 && phase != 1) drain();
            case ($urandom_range(5))
               0: v = 16'($urandom_range(20));
               1: v = 16'(10 ** $urandom_range(4)) - 16'd1 + 16'($urandom_range(2));
               2: case ($urandom_range(3))
                     0: v = 16'h7FFF;
                     1: v = 16'h8000;
                     2: v = 16'h8001;
                     default: v = 16'h0000;
                  endcase
               default: v = 16'($urandom);
            endcase
            if ($urandom_range(1)) v = -v;
            if ($urandom_range(9) < 8) w = 6'($urandom_range(12));
            else w = 6'($urandom_range(63, 13));
            case ($urandom_range(3))
               0: f = " ";
               1: f = "0";
               default: f = 8'($urandom);
            endcase
            send_item(v, w, f, "");
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         errors += expected_chars.size();
         $display("%0d expected characters never arrived", expected_chars.size());
      end
      $display("formatted %0d values: boundary table, then random values under four pacings",
               items_sent);
      $display("checked %0d characters, longest run %0d", chars_checked, longest_run);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
rtl/pdf_pkg.sv
rtl/padded_decimal_formatter.sv
test/padded_decimal_formatter_tb.sv
